// ===== design/elm_pkg.sv =====
// Shared types, switch bit positions and register indexes for the endstop limit monitor.
package elm_pkg;

	localparam int unsigned SW_W = 9;
	localparam int unsigned AX_W = 3;

	localparam int unsigned B_XMIN  = 0;
	localparam int unsigned B_XMAX  = 1;
	localparam int unsigned B_YMIN  = 2;
	localparam int unsigned B_YMAX  = 3;
	localparam int unsigned B_ZMIN  = 4;
	localparam int unsigned B_ZMAX  = 5;
	localparam int unsigned B_Z2MIN = 6;
	localparam int unsigned B_Z2MAX = 7;
	localparam int unsigned B_PROBE = 8;

	localparam int unsigned AX_X = 0;
	localparam int unsigned AX_Y = 1;
	localparam int unsigned AX_Z = 2;

	localparam logic [1:0] BOTH_Z = 2'b11;

	localparam logic [SW_W-1:0] INVERT_RESET  = 9'd0;
	localparam logic [SW_W-1:0] PRESENT_RESET = 9'd63;

	typedef enum logic [1:0] {
		REG_INVERT_MASK  = 2'd0,
		REG_PRESENT_MASK = 2'd1,
		REG_DUAL_Z_MODE  = 2'd2,
		REG_PROBE_CHECK  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [SW_W-1:0] invert_mask;
		logic [SW_W-1:0] present_mask;
		logic            dual_z_mode;
		logic            probe_check;
	} cfg_t;

	typedef struct packed {
		logic [SW_W-1:0] pin_levels;
		logic [AX_W-1:0] dir_negative;
		logic [AX_W-1:0] axis_moving;
		logic            homing_active;
		logic            clear_hits;
	} item_t;

	typedef struct packed {
		logic [AX_W-1:0] hit_latched;
		logic [AX_W-1:0] axis_triggered;
		logic            stop_move;
		logic [SW_W-1:0] qualified_bits;
	} result_t;

endpackage

// ===== design/elm_eval.sv =====
// Per-tick switch refresh, qualification, trigger and dual-Z stop evaluation.
module elm_eval (
	input  elm_pkg::cfg_t             cfg,
	input  elm_pkg::item_t            item,
	input  logic [elm_pkg::SW_W-1:0]  sample,
	input  logic [elm_pkg::SW_W-1:0]  prev,
	input  logic [elm_pkg::AX_W-1:0]  hits,
	output logic [elm_pkg::SW_W-1:0]  next_sample,
	output elm_pkg::result_t          res
);

	always_comb begin
		logic [elm_pkg::SW_W-1:0] act;
		logic [elm_pkg::SW_W-1:0] ns;
		logic [elm_pkg::SW_W-1:0] fit;
		logic [elm_pkg::SW_W-1:0] q;
		logic [elm_pkg::AX_W-1:0] trig;
		logic                     down;
		logic                     zq1;
		logic                     zq2;
		logic                     zfit;
		logic                     zhit;
		logic                     phit;
		logic                     stop;

		act  = item.pin_levels ^ cfg.invert_mask;
		fit  = cfg.present_mask;
		ns   = sample;
		down = item.dir_negative[elm_pkg::AX_Z];

		// Only the switch facing the direction of travel is refreshed.
		if (item.dir_negative[elm_pkg::AX_X]) begin
			if (fit[elm_pkg::B_XMIN]) ns[elm_pkg::B_XMIN] = act[elm_pkg::B_XMIN];
		end else begin
			if (fit[elm_pkg::B_XMAX]) ns[elm_pkg::B_XMAX] = act[elm_pkg::B_XMAX];
		end
		if (item.dir_negative[elm_pkg::AX_Y]) begin
			if (fit[elm_pkg::B_YMIN]) ns[elm_pkg::B_YMIN] = act[elm_pkg::B_YMIN];
		end else begin
			if (fit[elm_pkg::B_YMAX]) ns[elm_pkg::B_YMAX] = act[elm_pkg::B_YMAX];
		end
		if (down) begin
			if (fit[elm_pkg::B_ZMIN]) begin
				ns[elm_pkg::B_ZMIN] = act[elm_pkg::B_ZMIN];
				// In dual-Z mode, without a fitted Z2 switch its sample mirrors Z.
				if (cfg.dual_z_mode)
					ns[elm_pkg::B_Z2MIN] = fit[elm_pkg::B_Z2MIN] ?
						act[elm_pkg::B_Z2MIN] : act[elm_pkg::B_ZMIN];
			end
			if (cfg.probe_check && fit[elm_pkg::B_PROBE])
				ns[elm_pkg::B_PROBE] = act[elm_pkg::B_PROBE];
		end else begin
			if (fit[elm_pkg::B_ZMAX]) begin
				ns[elm_pkg::B_ZMAX] = act[elm_pkg::B_ZMAX];
				if (cfg.dual_z_mode)
					ns[elm_pkg::B_Z2MAX] = fit[elm_pkg::B_Z2MAX] ?
						act[elm_pkg::B_Z2MAX] : act[elm_pkg::B_ZMAX];
			end
		end

		q = ns & prev;

		trig = '0;
		trig[elm_pkg::AX_X] = item.dir_negative[elm_pkg::AX_X] ?
			(fit[elm_pkg::B_XMIN] & q[elm_pkg::B_XMIN]) :
			(fit[elm_pkg::B_XMAX] & q[elm_pkg::B_XMAX]);
		trig[elm_pkg::AX_Y] = item.dir_negative[elm_pkg::AX_Y] ?
			(fit[elm_pkg::B_YMIN] & q[elm_pkg::B_YMIN]) :
			(fit[elm_pkg::B_YMAX] & q[elm_pkg::B_YMAX]);

		zq1  = down ? q[elm_pkg::B_ZMIN]  : q[elm_pkg::B_ZMAX];
		zq2  = down ? q[elm_pkg::B_Z2MIN] : q[elm_pkg::B_Z2MAX];
		zfit = down ? fit[elm_pkg::B_ZMIN] : fit[elm_pkg::B_ZMAX];
		zhit = cfg.dual_z_mode ? (zfit & (zq1 | zq2)) : (zfit & zq1);
		phit = down & cfg.probe_check & fit[elm_pkg::B_PROBE] & q[elm_pkg::B_PROBE];
		trig[elm_pkg::AX_Z] = zhit | phit;
		trig = trig & item.axis_moving;

		// During homing a single Z side may touch first without aborting.
		stop = cfg.dual_z_mode & zhit & item.axis_moving[elm_pkg::AX_Z] &
			(~item.homing_active | ({zq2, zq1} == elm_pkg::BOTH_Z));

		next_sample        = ns;
		res.hit_latched    = (item.clear_hits ? '0 : hits) | trig;
		res.axis_triggered = trig;
		res.stop_move      = stop;
		res.qualified_bits = q;
	end

endmodule

// ===== design/endstop_limit_monitor_top.sv =====
// Top level of the endstop limit monitor: handshakes, registers and state.
// Path: an accepted item sits in the input register, its result is loaded into the result
// register when the item advances, and out_valid then rises; a stall can hold the item back.
// Throughput: one item per cycle while out_stall is low; a new item can enter while a result waits,
// and in_stall rises only when both registers are full and out_stall is high.
// Reset (arst_n low, asynchronous): stages empty, samples and hits cleared, registers default.
module endstop_limit_monitor_top (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [elm_pkg::SW_W-1:0] pin_levels,
	input  logic [elm_pkg::AX_W-1:0] dir_negative,
	input  logic [elm_pkg::AX_W-1:0] axis_moving,
	input  logic                     homing_active,
	input  logic                     clear_hits,

	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [elm_pkg::AX_W-1:0] hit_latched,
	output logic [elm_pkg::AX_W-1:0] axis_triggered,
	output logic                     stop_move,
	output logic [elm_pkg::SW_W-1:0] qualified_bits,

	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [elm_pkg::SW_W-1:0] cfg_data
);

	// Configuration registers; writes must arrive only while the block is idle, which the block does not enforce.
	elm_pkg::cfg_t cfg_q;

	// Input stage holds one accepted item until the result register can take it.
	logic           valid_s1;
	elm_pkg::item_t item_s1;

	// Switch state that survives from tick to tick.
	logic [elm_pkg::SW_W-1:0] sample_q;
	logic [elm_pkg::SW_W-1:0] prev_q;
	logic [elm_pkg::AX_W-1:0] hit_q;

	// Result register.
	logic             out_valid_q;
	elm_pkg::result_t res_q;

	logic                     advance;
	logic [elm_pkg::SW_W-1:0] next_sample;
	elm_pkg::result_t         res_d;

	// The item in stage 1 moves on when the result register is empty or being drained.
	assign advance  = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.invert_mask  <= elm_pkg::INVERT_RESET;
			cfg_q.present_mask <= elm_pkg::PRESENT_RESET;
			cfg_q.dual_z_mode  <= 1'b0;
			cfg_q.probe_check  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (elm_pkg::reg_idx_t'(cfg_index))
				elm_pkg::REG_INVERT_MASK:  cfg_q.invert_mask  <= cfg_data;
				elm_pkg::REG_PRESENT_MASK: cfg_q.present_mask <= cfg_data;
				elm_pkg::REG_DUAL_Z_MODE:  cfg_q.dual_z_mode  <= cfg_data[0];
				elm_pkg::REG_PROBE_CHECK:  cfg_q.probe_check  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.pin_levels    <= pin_levels;
			item_s1.dir_negative  <= dir_negative;
			item_s1.axis_moving   <= axis_moving;
			item_s1.homing_active <= homing_active;
			item_s1.clear_hits    <= clear_hits;
		end
	end

	elm_eval u_eval (
		.cfg         (cfg_q),
		.item        (item_s1),
		.sample      (sample_q),
		.prev        (prev_q),
		.hits        (hit_q),
		.next_sample (next_sample),
		.res         (res_d)
	);

	// The sample of this tick becomes the previous sample of the next tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
			prev_q   <= '0;
			hit_q    <= '0;
		end else if (advance) begin
			sample_q <= next_sample;
			prev_q   <= next_sample;
			hit_q    <= res_d.hit_latched;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign hit_latched    = res_q.hit_latched;
	assign axis_triggered = res_q.axis_triggered;
	assign stop_move      = res_q.stop_move;
	assign qualified_bits = res_q.qualified_bits;

	// A stop request always comes with a Z trigger.
	a_stop_has_z: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!res_q.stop_move || res_q.axis_triggered[elm_pkg::AX_Z]))
		else $error("stop_move without a Z trigger");

	// Every triggered axis is also latched.
	a_trig_latched: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((res_q.hit_latched & res_q.axis_triggered) == res_q.axis_triggered))
		else $error("triggered axis not latched");

	// The latched hit state matches the result just produced.
	a_hit_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (hit_q == res_q.hit_latched))
		else $error("hit state out of step with result");

	// Qualified switches are always within the newly stored previous sample.
	a_qual_subset: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> ((res_q.qualified_bits & ~prev_q) == '0))
		else $error("qualified bit not in stored sample");

endmodule
